>>> rtl/psu2x_pkg.sv
// Shared types, constants and pixel helpers for the 2x scanline upscaler.
`default_nettype none

package psu2x_pkg;

   localparam int LINE_WIDTH    = 320;
   localparam int FRAME_HEIGHT  = 240;
   localparam int PALETTE_DEPTH = 256;

   localparam int COL_W     = $clog2(LINE_WIDTH);
   localparam int ROW_W     = $clog2(FRAME_HEIGHT);
   localparam int PAL_AW    = $clog2(PALETTE_DEPTH);
   localparam int PIX_W     = 16;
   localparam int OUT_COL_W = 10;
   localparam int OUT_ROW_W = 9;
   localparam int CSR_IDX_W = 2;

   localparam logic FUNC_PIXEL   = 1'b0;
   localparam logic FUNC_PALETTE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_MODE = 2'd1;

   localparam logic COLOR_MODE_RESET = 1'b0;
   localparam logic SCALE_MODE_RESET = 1'b1;

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(LINE_WIDTH - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(FRAME_HEIGHT - 1);

   localparam logic [OUT_COL_W-1:0] FRAME_END_COL = OUT_COL_W'(2 * LINE_WIDTH - 1);
   localparam logic [OUT_ROW_W-1:0] FRAME_END_ROW = OUT_ROW_W'(2 * FRAME_HEIGHT - 1);

   typedef struct packed {
      logic             func;
      logic [PIX_W-1:0] pixel_value;
      logic [7:0]       pal_index;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]     color;
      logic [OUT_COL_W-1:0] out_col;
      logic [OUT_ROW_W-1:0] out_row;
      logic                 run_last;
      logic                 frame_done;
   } rsp_type;

   // Colors of one pixel's output area: top, middle and bottom rows, left and center columns.
   typedef struct packed {
      logic [PIX_W-1:0] tl;
      logic [PIX_W-1:0] tc;
      logic [PIX_W-1:0] ml;
      logic [PIX_W-1:0] mc;
      logic [PIX_W-1:0] bl;
      logic [PIX_W-1:0] bc;
   } blend_type;

   // Per-channel floor average of two RGB565 colors.
   function automatic logic [PIX_W-1:0] mix565(input logic [PIX_W-1:0] u,
                                               input logic [PIX_W-1:0] v);
      logic [5:0] r;
      logic [6:0] g;
      logic [5:0] b;
      r = {1'b0, u[15:11]} + {1'b0, v[15:11]};
      g = {1'b0, u[10:5]} + {1'b0, v[10:5]};
      b = {1'b0, u[4:0]} + {1'b0, v[4:0]};
      return {r[5:1], g[6:1], b[5:1]};
   endfunction

   function automatic logic [PIX_W-1:0] pal_entry(input logic [7:0] red,
                                                  input logic [7:0] green,
                                                  input logic [7:0] blue);
      return {red[7:3], green[7:2], blue[7:3]};
   endfunction

   // Default 3-3-2 palette entry for an index that was never written.
   function automatic logic [PIX_W-1:0] pal_default(input logic [PAL_AW-1:0] idx);
      logic [5:0] rr;
      logic [5:0] gg;
      logic [5:0] bb;
      rr = {3'b000, idx[7:5]} * 6'd5;
      gg = {3'b000, idx[4:2]} * 6'd9;
      bb = {4'b0000, idx[1:0]} * 6'd11;
      if (rr > 6'd31) begin
         rr = 6'd31;
      end
      if (bb > 6'd31) begin
         bb = 6'd31;
      end
      return {rr[4:0], gg, bb[4:0]};
   endfunction

endpackage

`default_nettype wire

>>> rtl/palette_scanline_upscaler_2x_core.sv
// Top level of the 2x scanline upscaler with palette lookup and linear blending.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------
//   req     | in        | req_valid/req_stall | req_type: pixel or palette write
//   rsp     | out       | rsp_valid/rsp_stall | rsp_type: color and coordinates
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// An interior source pixel yields four results, one per cycle while rsp is not stalled;
// a first-column pixel yields two, a last-row pixel up to twelve. The single result
// sequencer in front of the output register emits them. Palette writes and first-row
// pixels yield no results; a pixel passes the lookup stage, then the sequencer, to rsp.
// Reset is synchronous; it clears the palette valid bits so the default palette reads back.
// A stall on rsp holds the output register and backs up through the sequencer to req_stall.
`default_nettype none

module palette_scanline_upscaler_2x_core
   import psu2x_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire req_type              req_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      rsp_type              rsp_data,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic                 csr_data
);

   localparam logic [1:0] SEL_LEFT   = 2'd0;
   localparam logic [1:0] SEL_CENTER = 2'd1;
   localparam logic [1:0] SEL_RIGHT  = 2'd2;
   localparam logic [1:0] SEL_TOP    = 2'd0;
   localparam logic [1:0] SEL_MID    = 2'd1;
   localparam logic [1:0] SEL_BOTTOM = 2'd3;

   // Configuration.
   logic color_mode_ff;
   logic scale_mode_ff;

   // Memories and their registered read data.
   logic [PIX_W-1:0]         pal_mem_ff [PALETTE_DEPTH];
   logic [PALETTE_DEPTH-1:0] pal_vld_ff;
   logic [PIX_W-1:0]         pal_rd_ff;
   logic                     pal_vld_rd_ff;
   logic [PIX_W-1:0]         line_mem_ff [LINE_WIDTH];
   logic [PIX_W-1:0]         line_rd_ff;

   // Source position of the next pixel.
   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;

   // Neighbor state.
   logic [PIX_W-1:0] prev_pixel_ff;
   logic [PIX_W-1:0] prev_above_ff;

   // Lookup stage.
   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;

   // Result sequencer stage.
   logic             s2_valid_ff;
   logic             s2_valid_in;
   blend_type        s2_blend_ff;
   logic [COL_W-1:0] s2_col_ff;
   logic [ROW_W-1:0] s2_row_ff;
   logic             s2_first_col_ff;
   logic             s2_last_col_ff;
   logic             s2_last_row_ff;
   logic [1:0]       rsel_ff;
   logic [1:0]       rsel_in;
   logic [1:0]       csel_ff;
   logic [1:0]       csel_in;

   // Output register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // Combinational control.
   logic             req_accept;
   logic             pix_accept;
   logic             pal_write;
   logic             s1_has_out;
   logic             s1_adv;
   logic             s1_load;
   logic             s2_take;
   logic             s2_done;
   logic             out_ready;
   logic             emit;
   logic [PIX_W-1:0] cur_d;
   logic [PIX_W-1:0] cur_b;
   blend_type        blend;
   logic [1:0]       csel_start;
   logic [1:0]       csel_end;
   logic [1:0]       rsel_end;
   logic             s2_is_last;
   logic [1:0]       rsel_inc;
   logic [1:0]       csel_inc;
   logic [COL_W+1:0] col_sum;
   logic [ROW_W+1:0] row_sum;
   rsp_type          result;

   // Handshake and stage control.
   always_comb begin
      out_ready  = !rsp_valid_ff || !rsp_stall;
      emit       = s2_valid_ff && out_ready;
      s2_done    = emit && s2_is_last;
      s2_take    = !s2_valid_ff || s2_done;
      s1_has_out = (s1_row_ff != '0);
      s1_adv     = s1_valid_ff && (!s1_has_out || s2_take);
      s1_load    = s1_adv && s1_has_out;
      req_stall  = s1_valid_ff && !s1_adv;
      req_accept = req_valid && !req_stall;
      pix_accept = req_accept && (req_data.func == FUNC_PIXEL);
      pal_write  = req_accept && (req_data.func == FUNC_PALETTE);
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= COLOR_MODE_RESET;
         scale_mode_ff <= SCALE_MODE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COLOR_MODE: color_mode_ff <= csr_data;
            CSR_SCALE_MODE: scale_mode_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Palette: written at acceptance, so a pixel right behind a write already sees it.
   always_ff @(posedge clock) begin
      if (pal_write) begin
         pal_mem_ff[req_data.pal_index] <= pal_entry(req_data.red, req_data.green,
                                                     req_data.blue);
      end
      if (pix_accept) begin
         pal_rd_ff <= pal_mem_ff[req_data.pixel_value[PAL_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_vld_ff    <= '0;
         pal_vld_rd_ff <= 1'b0;
      end else begin
         if (pal_write) begin
            pal_vld_ff[req_data.pal_index] <= 1'b1;
         end
         if (pix_accept) begin
            pal_vld_rd_ff <= pal_vld_ff[req_data.pixel_value[PAL_AW-1:0]];
         end
      end
   end

   // Line store: the read for the next pixel and the write-back of the pixel leaving the
   // lookup stage may share an edge, and then address neighboring columns but at a line wrap.
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         line_mem_ff[s1_col_ff] <= cur_d;
      end
      if (pix_accept) begin
         line_rd_ff <= line_mem_ff[col_ff];
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (pix_accept) begin
         if (col_ff == LAST_COL) begin
            col_in = '0;
            row_in = (row_ff == LAST_ROW) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Lookup stage.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pix_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_accept) begin
         s1_pix_ff <= req_data.pixel_value;
         s1_col_ff <= col_ff;
         s1_row_ff <= row_ff;
      end
   end

   always_comb begin
      cur_b = line_rd_ff;
      if (color_mode_ff) begin
         cur_d = pal_vld_rd_ff ? pal_rd_ff : pal_default(s1_pix_ff[PAL_AW-1:0]);
      end else begin
         cur_d = s1_pix_ff;
      end
      if (scale_mode_ff) begin
         blend.bl = mix565(prev_pixel_ff, cur_d);
         blend.bc = cur_d;
         blend.tl = mix565(prev_above_ff, cur_b);
         blend.tc = cur_b;
         blend.ml = mix565(blend.tl, blend.bl);
         blend.mc = mix565(cur_b, cur_d);
      end else begin
         blend.tl = prev_above_ff;
         blend.tc = cur_b;
         blend.ml = prev_above_ff;
         blend.mc = cur_b;
         blend.bl = prev_pixel_ff;
         blend.bc = cur_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pixel_ff <= '0;
         prev_above_ff <= '0;
      end else if (s1_adv) begin
         prev_pixel_ff <= cur_d;
         prev_above_ff <= cur_b;
      end
   end

   // Result sequencer: walks the columns of each output row, row by row, over the output area of one pixel.
   always_comb begin
      csel_start = s2_first_col_ff ? SEL_CENTER : SEL_LEFT;
      csel_end   = s2_last_col_ff ? SEL_RIGHT : SEL_CENTER;
      rsel_end   = s2_last_row_ff ? SEL_BOTTOM : SEL_MID;
      s2_is_last = (rsel_ff == rsel_end) && (csel_ff == csel_end);
      rsel_inc   = rsel_ff + 1'b1;
      csel_inc   = csel_ff + 1'b1;

      s2_valid_in = s2_valid_ff;
      rsel_in     = rsel_ff;
      csel_in     = csel_ff;
      if (s1_load) begin
         s2_valid_in = 1'b1;
         rsel_in     = SEL_TOP;
         csel_in     = (s1_col_ff == '0) ? SEL_CENTER : SEL_LEFT;
      end else if (s2_done) begin
         s2_valid_in = 1'b0;
      end else if (emit) begin
         if (csel_ff == csel_end) begin
            csel_in = csel_start;
            rsel_in = rsel_inc;
         end else begin
            csel_in = csel_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         rsel_ff     <= SEL_TOP;
         csel_ff     <= SEL_LEFT;
      end else begin
         s2_valid_ff <= s2_valid_in;
         rsel_ff     <= rsel_in;
         csel_ff     <= csel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s2_blend_ff     <= blend;
         s2_col_ff       <= s1_col_ff;
         s2_row_ff       <= s1_row_ff;
         s2_first_col_ff <= (s1_col_ff == '0);
         s2_last_col_ff  <= (s1_col_ff == LAST_COL);
         s2_last_row_ff  <= (s1_row_ff == LAST_ROW);
      end
   end

   always_comb begin
      // Output column 2x-1+csel and row 2y-2+rsel; both stay non-negative.
      col_sum = {s2_col_ff, 1'b0} + {{COL_W{1'b0}}, csel_ff} - 1'b1;
      row_sum = {s2_row_ff, 1'b0} + {{ROW_W{1'b0}}, rsel_ff} - 2'd2;
      case (rsel_ff)
         SEL_TOP: result.color = (csel_ff == SEL_LEFT) ? s2_blend_ff.tl : s2_blend_ff.tc;
         SEL_MID: result.color = (csel_ff == SEL_LEFT) ? s2_blend_ff.ml : s2_blend_ff.mc;
         default: result.color = (csel_ff == SEL_LEFT) ? s2_blend_ff.bl : s2_blend_ff.bc;
      endcase
      result.out_col    = OUT_COL_W'(col_sum);
      result.out_row    = OUT_ROW_W'(row_sum);
      result.run_last   = s2_is_last;
      result.frame_done = s2_is_last && s2_last_col_ff && s2_last_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= result;
      end
   end

endmodule

`default_nettype wire

>>> rtl/psu2x_checker.sv
// Port-level checks for the 2x scanline upscaler, bound to its top level.
`default_nettype none

module psu2x_checker
   import psu2x_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire req_type              req_data,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire rsp_type              rsp_data,
   input wire logic                 csr_valid,
   input wire logic                 csr_ready,
   input wire logic [CSR_IDX_W-1:0] csr_index,
   input wire logic                 csr_data
);

   // A stalled result transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // The end of a frame is the last result of its pixel, at the far corner.
   a_frame_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |-> rsp_data.run_last
         && (rsp_data.out_col == FRAME_END_COL) && (rsp_data.out_row == FRAME_END_ROW))
      else $error("frame_done away from the last output pixel");

   // Every pixel's output area ends on an odd output row.
   a_run_odd_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.run_last |-> rsp_data.out_row[0])
      else $error("run_last on an even output row");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind palette_scanline_upscaler_2x_core psu2x_checker u_psu2x_checker (.*);

`default_nettype wire
